@@ hdl/imh_pkg.sv @@
`timescale 1ns / 1ps
package imh_pkg;
  localparam int CAPACITY = 256;
  localparam int ID_COUNT = 1024;
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(ID_COUNT);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELMIN = 2'd1,
    MODE_SETKEY = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [9:0]         item_id;
    logic signed [31:0] item_key;
    logic [31:0]        item_payload;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [9:0]         out_id;
    logic signed [31:0] out_key;
    logic [31:0]        out_payload;
  } rsp_t;

  typedef struct packed {
    logic [9:0]         id;
    logic signed [31:0] key;
    logic [31:0]        payload;
  } entry_t;

  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } pos_t;
endpackage

@@ hdl/indexed_min_heap.sv @@
`timescale 1ns / 1ps
// Requests are handled one at a time: in_stall is high outside S_IDLE. An entry moves up one
// level per S_UPST/S_UPRD pass and down one level per S_DNST/S_DNRD1 (and S_DNRD2 for a second
// child) pass, since the heap memory has one read port, one read a cycle.
// A new request is taken while the previous response waits at the output register.
// Reset (rst_n low, synchronous) empties the heap, then a clearing pass over all ID_COUNT
// entries (1024) zeroes the id table; no request is taken during that pass.
module indexed_min_heap
  import imh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_rsp
);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_LOOK   = 11'b00000000100,
    S_HEADRD = 11'b00000001000,
    S_LASTRD = 11'b00000010000,
    S_UPST   = 11'b00000100000,
    S_UPRD   = 11'b00001000000,
    S_DNST   = 11'b00010000000,
    S_DNRD1  = 11'b00100000000,
    S_DNRD2  = 11'b01000000000,
    S_FINISH = 11'b10000000000
  } state_t;

  state_t            state_r;
  req_t              req_r;
  entry_t            item_r;
  entry_t            childa_r;
  logic [SLOT_W-1:0] hole_r;
  logic [SLOT_W-1:0] pos_r;
  logic [SLOT_W-1:0] c_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              settle_r;
  rsp_t              rsp_r;
  rsp_t              out_rsp_r;
  logic              out_valid_r;
  logic [IDX_W-1:0]  clr_r;

  entry_t heap_mem [CAPACITY];
  pos_t   idt_mem  [ID_COUNT];
  entry_t heap_q;
  pos_t   idt_q;

  logic [SLOT_W-1:0] heap_raddr;
  logic [IDX_W-1:0]  idt_raddr;
  logic              heap_we;
  logic [SLOT_W-1:0] heap_waddr;
  entry_t            heap_wdata;
  logic              idt_we;
  logic [IDX_W-1:0]  idt_waddr;
  pos_t              idt_wdata;

  logic [CNT_W:0]    c_w;
  logic [CNT_W-1:0]  c_inc;
  logic [CNT_W-1:0]  cnt_dec;
  logic              need_b;
  logic              pick_b;
  entry_t            dn_cand;
  logic [SLOT_W-1:0] dn_idx;
  logic              dn_move;
  logic              decide;
  logic              up_move;
  logic              accept;
  logic              out_free;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // first child of the hole: the root has node 1 as its only child
  assign c_w = (hole_r == '0) ? (CNT_W + 1)'(1) : (CNT_W + 1)'({hole_r, 1'b0});
  assign c_inc   = CNT_W'(c_r) + CNT_W'(1);
  assign cnt_dec = cnt_r - CNT_W'(1);
  assign need_b  = (hole_r != '0) && (c_inc < cnt_r);
  assign pick_b  = (state_r == S_DNRD2) && (heap_q.key < childa_r.key);
  assign dn_cand = (state_r == S_DNRD2) ? (pick_b ? heap_q : childa_r) : heap_q;
  assign dn_idx  = pick_b ? c_inc[SLOT_W-1:0] : c_r;
  assign dn_move = dn_cand.key < item_r.key;
  assign decide  = (state_r == S_DNRD2) || ((state_r == S_DNRD1) && !need_b);
  assign up_move = item_r.key < heap_q.key;

  always_comb begin
    heap_raddr = '0;
    idt_raddr  = in_req.item_id[IDX_W-1:0];
    case (state_r)
      S_LOOK:   heap_raddr = idt_q.slot;
      S_HEADRD: heap_raddr = cnt_dec[SLOT_W-1:0];
      S_UPST:   heap_raddr = hole_r >> 1;
      S_DNST:   heap_raddr = c_w[SLOT_W-1:0];
      S_DNRD1:  heap_raddr = c_inc[SLOT_W-1:0];
      default:  heap_raddr = '0;
    endcase
  end

  always_comb begin
    logic fin;
    fin        = 1'b0;
    heap_we    = 1'b0;
    heap_waddr = hole_r;
    heap_wdata = item_r;
    idt_we     = 1'b0;
    idt_waddr  = item_r.id[IDX_W-1:0];
    idt_wdata  = '{present: 1'b1, slot: hole_r};
    case (state_r)
      S_CLEAR: begin
        idt_we    = 1'b1;
        idt_waddr = clr_r;
        idt_wdata = '0;
      end
      S_HEADRD: begin
        if (req_r.mode == MODE_DELMIN) begin
          idt_we    = 1'b1;
          idt_waddr = heap_q.id[IDX_W-1:0];
          idt_wdata = '0;
        end else if (req_r.mode == MODE_REMOVE) begin
          idt_we    = 1'b1;
          idt_waddr = req_r.item_id[IDX_W-1:0];
          idt_wdata = '0;
        end
      end
      S_UPST: fin = (hole_r == '0) && !settle_r;
      S_UPRD: begin
        if (up_move) begin
          heap_we    = 1'b1;
          heap_wdata = heap_q;
          idt_we     = 1'b1;
          idt_waddr  = heap_q.id[IDX_W-1:0];
        end else begin
          fin = !settle_r;
        end
      end
      S_DNST: fin = (c_w >= (CNT_W + 1)'(cnt_r));
      S_DNRD1, S_DNRD2: begin
        if (decide) begin
          if (dn_move) begin
            heap_we    = 1'b1;
            heap_wdata = dn_cand;
            idt_we     = 1'b1;
            idt_waddr  = dn_cand.id[IDX_W-1:0];
          end else begin
            fin = 1'b1;
          end
        end
      end
      default: fin = 1'b0;
    endcase
    if (fin) begin
      heap_we = 1'b1;
      idt_we  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
    heap_q <= heap_mem[heap_raddr];
  end

  always_ff @(posedge clk) begin
    if (idt_we) idt_mem[idt_waddr] <= idt_wdata;
    idt_q <= idt_mem[idt_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      clr_r       <= '0;
      settle_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_FINISH) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + IDX_W'(1);
          if (clr_r == IDX_W'(ID_COUNT - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            req_r <= in_req;
            if (in_req.mode == MODE_DELMIN) begin
              if (cnt_r == '0) begin
                rsp_r   <= '{status: ST_EMPTY, out_id: '0, out_key: '0, out_payload: '0};
                state_r <= S_FINISH;
              end else begin
                rsp_r   <= '0;
                state_r <= S_HEADRD;
              end
            end else if (in_req.mode == MODE_INSERT && cnt_r == CNT_W'(CAPACITY)) begin
              rsp_r   <= '{status: ST_FULL, out_id: '0, out_key: '0, out_payload: '0};
              state_r <= S_FINISH;
            end else begin
              rsp_r   <= '0;
              state_r <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (req_r.mode == MODE_INSERT) begin
            if (idt_q.present) begin
              rsp_r.status <= ST_DUP;
              state_r      <= S_FINISH;
            end else begin
              item_r   <= '{id: req_r.item_id, key: req_r.item_key,
                            payload: req_r.item_payload};
              hole_r   <= cnt_r[SLOT_W-1:0];
              cnt_r    <= cnt_r + CNT_W'(1);
              settle_r <= 1'b0;
              state_r  <= S_UPST;
            end
          end else if (!idt_q.present || CNT_W'(idt_q.slot) >= cnt_r) begin
            rsp_r.status <= ST_MISSING;
            state_r      <= S_FINISH;
          end else begin
            pos_r   <= idt_q.slot;
            hole_r  <= idt_q.slot;
            state_r <= S_HEADRD;
          end
        end
        S_HEADRD: begin
          case (req_r.mode)
            MODE_DELMIN: begin
              rsp_r   <= '{status: ST_OK, out_id: heap_q.id, out_key: heap_q.key,
                           out_payload: heap_q.payload};
              cnt_r   <= cnt_dec;
              hole_r  <= '0;
              state_r <= (cnt_dec != '0) ? S_LASTRD : S_FINISH;
            end
            MODE_SETKEY: begin
              item_r   <= '{id: heap_q.id, key: req_r.item_key, payload: heap_q.payload};
              settle_r <= 1'b1;
              state_r  <= S_UPST;
            end
            MODE_REMOVE: begin
              rsp_r   <= '{status: ST_OK, out_id: '0, out_key: heap_q.key,
                           out_payload: heap_q.payload};
              cnt_r   <= cnt_dec;
              state_r <= (CNT_W'(pos_r) < cnt_dec) ? S_LASTRD : S_FINISH;
            end
            default: state_r <= S_FINISH;
          endcase
        end
        S_LASTRD: begin
          item_r <= heap_q;
          if (req_r.mode == MODE_DELMIN) begin
            settle_r <= 1'b0;
            state_r  <= S_DNST;
          end else begin
            settle_r <= 1'b1;
            state_r  <= S_UPST;
          end
        end
        S_UPST: begin
          if (hole_r != '0) begin
            state_r <= S_UPRD;
          end else if (settle_r) begin
            settle_r <= 1'b0;
            state_r  <= S_DNST;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_UPRD: begin
          if (up_move) begin
            hole_r   <= hole_r >> 1;
            settle_r <= 1'b0;
            state_r  <= S_UPST;
          end else if (settle_r) begin
            settle_r <= 1'b0;
            state_r  <= S_DNST;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_DNST: begin
          if (c_w >= (CNT_W + 1)'(cnt_r)) begin
            state_r <= S_FINISH;
          end else begin
            c_r     <= c_w[SLOT_W-1:0];
            state_r <= S_DNRD1;
          end
        end
        S_DNRD1, S_DNRD2: begin
          if (!decide) begin
            childa_r <= heap_q;
            state_r  <= S_DNRD2;
          end else if (dn_move) begin
            hole_r  <= dn_idx;
            state_r <= S_DNST;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_rsp_r   <= rsp_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_valid_r && out_stall) |=> (state_r == S_FINISH))
    else $error("response overwritten while output stalled");

  a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOOK && state_r != S_HEADRD) |=> $stable(cnt_r))
    else $error("entry count changed outside its update states");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall)
    else $error("request taken during clearing pass");

endmodule
